>>> src/rect_track_association_table_core_macros.svh
// assertion macros for the rectangle track table core
// used by rect_track_association_table_core.sv, needs i_clk and i_rst_n in scope
`ifndef RECT_TRACK_ASSOCIATION_TABLE_CORE_MACROS_SVH
`define RECT_TRACK_ASSOCIATION_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define RTAT_ASSERT_NOW(label, cond, consq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (consq)) \
        else $error(msg);

// next-cycle implication
`define RTAT_ASSERT_NEXT(label, cond, consq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

>>> src/rtat_pkg.sv
// types and constants of the rectangle track table
// no dependencies
`timescale 1ns / 1ps

package rtat_pkg;

    localparam int COORD_W       = 16;
    localparam int ANGLE_W       = 12;
    localparam int AREA_IN_W     = 21;
    localparam int RADIUS_W      = 8;
    localparam int STATUS_W      = 3;
    localparam int MATCH_CNT_W   = 5;
    localparam int ENTRY_IDX_W   = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 21;

    localparam logic [RADIUS_W-1:0]  MATCH_RADIUS_RST = 8'd20;
    localparam logic [AREA_IN_W-1:0] MIN_AREA_RST     = 21'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA     = 2'd1;

    localparam logic FUNC_SUBMIT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCHED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUMP     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

    typedef struct packed {
        logic                       func;
        logic [COORD_W-1:0]         center_x;
        logic [COORD_W-1:0]         center_y;
        logic [COORD_W-1:0]         rect_width;
        logic [COORD_W-1:0]         rect_height;
        logic signed [ANGLE_W-1:0]  rect_angle;
        logic [AREA_IN_W-1:0]       contour_area;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [MATCH_CNT_W-1:0]     match_count;
        logic [ENTRY_IDX_W-1:0]     entry_index;
        logic [COORD_W-1:0]         out_center_x;
        logic [COORD_W-1:0]         out_center_y;
        logic [COORD_W-1:0]         out_width;
        logic [COORD_W-1:0]         out_height;
        logic signed [ANGLE_W-1:0]  out_angle;
        logic                       last;
    } t_res;

    typedef struct packed {
        logic [COORD_W-1:0]         center_x;
        logic [COORD_W-1:0]         center_y;
        logic [COORD_W-1:0]         width;
        logic [COORD_W-1:0]         height;
        logic signed [ANGLE_W-1:0]  angle;
    } t_entry;

endpackage

>>> src/rect_track_association_table_core.sv
// rectangle track table: entry memory, similarity scan pipeline, dump and result logic
// depends on rtat_pkg and rect_track_association_table_core_macros.svh
`timescale 1ns / 1ps
`include "rect_track_association_table_core_macros.svh"

//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------
//  in      | to core   | i_in_valid / o_in_stall     | i_in_req (t_req)
//  out     | from core | o_out_valid / i_out_stall   | o_out_res (t_res)
//  cfg     | to core   | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// a submit: products set up in S_PREP and S_PREP2 (an area under the minimum skips to
// the result), one read a cycle over the filled slots, a pipeline drain, then the result
// a dump reads the entries one at a time through the single memory read port
// one request is worked on at a time; a new one is taken while the last result waits
// reset is synchronous, active low; it empties the table, memory contents are not cleared

module rect_track_association_table_core #(
    parameter int TABLE_DEPTH     = 16,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rtat_pkg::t_req                      i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rtat_pkg::t_res                      o_out_res,
    input  logic                                i_cfg_we,
    input  logic [rtat_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtat_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RAD_W    = rtat_pkg::RADIUS_W + COORD_FRAC_BITS;
    localparam int RSQ_W    = 2 * RAD_W;
    localparam int AREA_W   = 2 * rtat_pkg::COORD_W;
    localparam int DSQ_W    = AREA_W + 1;
    localparam int CMP_W    = (RSQ_W > DSQ_W) ? RSQ_W : DSQ_W;
    localparam int AREA_X_W = AREA_W + 4;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PREP    = 3'd1;
    localparam logic [2:0] S_PREP2   = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_RESULT  = 3'd4;
    localparam logic [2:0] S_DUMP_RD = 3'd5;
    localparam logic [2:0] S_DUMP_LD = 3'd6;

    // configuration
    logic [rtat_pkg::RADIUS_W-1:0]  r_match_radius;
    logic [rtat_pkg::AREA_IN_W-1:0] r_min_area;

    // control
    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_iss_cnt, n_iss_cnt;
    logic [CNT_W-1:0]   r_matches, n_matches;
    logic               r_v1, n_v1;
    logic               r_v2, n_v2;
    logic               r_out_valid;

    // payload
    rtat_pkg::t_req     r_req;
    rtat_pkg::t_res     r_out_res, n_out_res;
    rtat_pkg::t_entry   r_rd_data;
    logic               r_small;
    logic [AREA_W-1:0]  r_a_new;
    logic [RSQ_W-1:0]   r_rad_sq;
    logic [AREA_X_W-1:0] r_a7, r_a14;
    logic [IDX_W-1:0]   r_idx1, r_idx2;
    logic [AREA_W-1:0]  r_sqx, r_sqy, r_aold;

    rtat_pkg::t_entry   mem_tab [TABLE_DEPTH];

    logic               out_free, out_load;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    rtat_pkg::t_entry   mem_wdata;
    logic [RAD_W-1:0]   rad;
    logic [rtat_pkg::COORD_W-1:0] dx, dy;
    logic [DSQ_W-1:0]   dist_sq;
    logic [AREA_X_W-1:0] ten_old;
    logic               hit;
    logic [CNT_W+rtat_pkg::ENTRY_IDX_W-1:0] iss_wide, cnt_wide;
    logic [CNT_W+rtat_pkg::MATCH_CNT_W-1:0] mat_wide;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign rad = RAD_W'(r_match_radius) << COORD_FRAC_BITS;

    // stage 1: distances and stored area
    assign dx = (r_rd_data.center_x > r_req.center_x) ? r_rd_data.center_x - r_req.center_x
                                                      : r_req.center_x - r_rd_data.center_x;
    assign dy = (r_rd_data.center_y > r_req.center_y) ? r_rd_data.center_y - r_req.center_y
                                                      : r_req.center_y - r_rd_data.center_y;

    // stage 2: similarity decision
    assign dist_sq = DSQ_W'(r_sqx) + DSQ_W'(r_sqy);
    assign ten_old = (AREA_X_W'(r_aold) << 3) + (AREA_X_W'(r_aold) << 1);
    assign hit     = (CMP_W'(dist_sq) <= CMP_W'(r_rad_sq)) && (ten_old <= r_a14)
                     && (ten_old >= r_a7);

    assign iss_wide = (CNT_W + rtat_pkg::ENTRY_IDX_W)'(r_iss_cnt);
    assign cnt_wide = (CNT_W + rtat_pkg::ENTRY_IDX_W)'(r_count);
    assign mat_wide = (CNT_W + rtat_pkg::MATCH_CNT_W)'(r_matches);

    assign rd_addr   = r_iss_cnt[IDX_W-1:0];
    assign rd_en     = ((r_state == S_SCAN) && (r_iss_cnt != r_count)) || (r_state == S_DUMP_RD);
    assign mem_waddr = (r_state == S_SCAN) ? r_idx2 : r_count[IDX_W-1:0];

    always_comb begin
        mem_wdata.center_x = r_req.center_x;
        mem_wdata.center_y = r_req.center_y;
        mem_wdata.width    = r_req.rect_width;
        mem_wdata.height   = r_req.rect_height;
        mem_wdata.angle    = r_req.rect_angle;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_iss_cnt = r_iss_cnt;
        n_matches = r_matches;
        n_v1      = 1'b0;
        n_v2      = r_v1;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        n_out_res = '0;
        n_out_res.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_iss_cnt = '0;
                    if (i_in_req.func == rtat_pkg::FUNC_DUMP) begin
                        n_state = (r_count == '0) ? S_RESULT : S_DUMP_RD;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                n_matches = '0;
                n_state   = (r_req.contour_area < r_min_area) ? S_RESULT : S_PREP2;
            end
            S_PREP2: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_iss_cnt != r_count) begin
                    n_v1      = 1'b1;
                    n_iss_cnt = r_iss_cnt + 1'b1;
                end
                if (r_v2 && hit) begin
                    mem_we    = 1'b1;
                    n_matches = r_matches + 1'b1;
                end
                if ((r_iss_cnt == r_count) && !r_v1 && !r_v2) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_req.func == rtat_pkg::FUNC_DUMP) begin
                        n_out_res.status = rtat_pkg::ST_EMPTY;
                    end else if (r_small) begin
                        n_out_res.status = rtat_pkg::ST_IGNORED;
                    end else if (r_matches != '0) begin
                        n_out_res.status      = rtat_pkg::ST_MATCHED;
                        n_out_res.match_count = mat_wide[rtat_pkg::MATCH_CNT_W-1:0];
                    end else if (r_count >= DEPTH_C) begin
                        n_out_res.status = rtat_pkg::ST_FULL;
                    end else begin
                        n_out_res.status      = rtat_pkg::ST_APPENDED;
                        n_out_res.entry_index = cnt_wide[rtat_pkg::ENTRY_IDX_W-1:0];
                        mem_we                = 1'b1;
                        n_count               = r_count + 1'b1;
                    end
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out_res.status       = rtat_pkg::ST_DUMP;
                    n_out_res.entry_index  = iss_wide[rtat_pkg::ENTRY_IDX_W-1:0];
                    n_out_res.out_center_x = r_rd_data.center_x;
                    n_out_res.out_center_y = r_rd_data.center_y;
                    n_out_res.out_width    = r_rd_data.width;
                    n_out_res.out_height   = r_rd_data.height;
                    n_out_res.out_angle    = r_rd_data.angle;
                    n_out_res.last         = (r_iss_cnt + 1'b1 == r_count);
                    if (r_iss_cnt + 1'b1 == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        n_iss_cnt = r_iss_cnt + 1'b1;
                        n_state   = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_iss_cnt      <= '0;
            r_matches      <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_out_valid    <= 1'b0;
            r_match_radius <= rtat_pkg::MATCH_RADIUS_RST;
            r_min_area     <= rtat_pkg::MIN_AREA_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_iss_cnt <= n_iss_cnt;
            r_matches <= n_matches;
            r_v1      <= n_v1;
            r_v2      <= n_v2;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rtat_pkg::REG_MATCH_RADIUS: begin
                        r_match_radius <= i_cfg_data[rtat_pkg::RADIUS_W-1:0];
                    end
                    rtat_pkg::REG_MIN_AREA: begin
                        r_min_area <= i_cfg_data[rtat_pkg::AREA_IN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (r_state == S_PREP) begin
            r_small  <= (r_req.contour_area < r_min_area);
            r_a_new  <= AREA_W'(r_req.rect_width) * AREA_W'(r_req.rect_height);
            r_rad_sq <= RSQ_W'(rad) * RSQ_W'(rad);
        end
        if (r_state == S_PREP2) begin
            r_a7  <= (AREA_X_W'(r_a_new) << 3) - AREA_X_W'(r_a_new);
            r_a14 <= (AREA_X_W'(r_a_new) << 4) - (AREA_X_W'(r_a_new) << 1);
        end
        if (out_load) begin
            r_out_res <= n_out_res;
        end
        r_idx1 <= rd_addr;
        r_idx2 <= r_idx1;
        r_sqx  <= AREA_W'(dx) * AREA_W'(dx);
        r_sqy  <= AREA_W'(dy) * AREA_W'(dy);
        r_aold <= AREA_W'(r_rd_data.width) * AREA_W'(r_rd_data.height);
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_tab[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem_tab[rd_addr];
        end
    end

    `RTAT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= DEPTH_C, "entry count beyond table depth")
    `RTAT_ASSERT_NOW(a_scan_write_slot, (r_state == S_SCAN) && mem_we,
        CNT_W'(r_idx2) < r_count, "overwrite outside filled slots")
    `RTAT_ASSERT_NEXT(a_append_count, (r_state == S_RESULT) && mem_we,
        r_count == $past(r_count) + 1'b1, "append did not grow the table")

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the rectangle track table core: directed and random requests
// depends on rtat_pkg and rect_track_association_table_core
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS    = 4;
    localparam int DEPTH        = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;
    localparam int AREA_MAX     = (1 << rtat_pkg::AREA_IN_W) - 1;
    localparam int COORD_MAX    = (1 << rtat_pkg::COORD_W) - 1;
    localparam int ANGLE_LIM    = 1440;
    localparam logic [rtat_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    class track_scoreboard;
        rtat_pkg::t_entry               tracks [DEPTH];
        int unsigned                    fill;
        logic [rtat_pkg::RADIUS_W-1:0]  radius;
        logic [rtat_pkg::AREA_IN_W-1:0] min_area;
        rtat_pkg::t_res                 expected [$];
        int unsigned                    mismatches;

        function new();
            fill       = 0;
            radius     = rtat_pkg::MATCH_RADIUS_RST;
            min_area   = rtat_pkg::MIN_AREA_RST;
            mismatches = 0;
        endfunction

        function void write_reg(logic [rtat_pkg::CFG_IDX_W-1:0] idx,
                                logic [rtat_pkg::CFG_DATA_W-1:0] data);
            if (idx == rtat_pkg::REG_MATCH_RADIUS) begin
                radius = data[rtat_pkg::RADIUS_W-1:0];
            end else if (idx == rtat_pkg::REG_MIN_AREA) begin
                min_area = data[rtat_pkg::AREA_IN_W-1:0];
            end
        endfunction

        function void add_expected(rtat_pkg::t_res r);
            expected = {expected, r};
        endfunction

        function bit similar(rtat_pkg::t_entry e, rtat_pkg::t_req r);
            longint unsigned ox, oy, nx, ny, dx, dy, rad, ow, oh, nw, nh, a_old, a_new;
            ox = e.center_x;
            oy = e.center_y;
            nx = r.center_x;
            ny = r.center_y;
            ow = e.width;
            oh = e.height;
            nw = r.rect_width;
            nh = r.rect_height;
            dx = (ox > nx) ? ox - nx : nx - ox;
            dy = (oy > ny) ? oy - ny : ny - oy;
            rad = longint'(radius) << FRAC_BITS;
            a_old = ow * oh;
            a_new = nw * nh;
            return (dx * dx + dy * dy <= rad * rad) && (10 * a_old <= 14 * a_new)
                && (10 * a_old >= 7 * a_new);
        endfunction

        function void note_request(rtat_pkg::t_req r);
            rtat_pkg::t_res res;
            int unsigned    hits;
            res = '0;
            res.last = 1'b1;
            hits = 0;
            if (r.func == rtat_pkg::FUNC_DUMP) begin
                if (fill == 0) begin
                    res.status = rtat_pkg::ST_EMPTY;
                    add_expected(res);
                end else begin
                    for (int i = 0; i < fill; i++) begin
                        res.status       = rtat_pkg::ST_DUMP;
                        res.entry_index  = i[rtat_pkg::ENTRY_IDX_W-1:0];
                        res.out_center_x = tracks[i].center_x;
                        res.out_center_y = tracks[i].center_y;
                        res.out_width    = tracks[i].width;
                        res.out_height   = tracks[i].height;
                        res.out_angle    = tracks[i].angle;
                        res.last         = (i + 1 == fill);
                        add_expected(res);
                    end
                end
                return;
            end
            if (r.contour_area < min_area) begin
                res.status = rtat_pkg::ST_IGNORED;
                add_expected(res);
                return;
            end
            for (int i = 0; i < fill; i++) begin
                if (similar(tracks[i], r)) begin
                    tracks[i] = '{r.center_x, r.center_y, r.rect_width, r.rect_height,
                                  r.rect_angle};
                    hits++;
                end
            end
            if (hits > 0) begin
                res.status      = rtat_pkg::ST_MATCHED;
                res.match_count = hits[rtat_pkg::MATCH_CNT_W-1:0];
            end else if (fill >= DEPTH) begin
                res.status = rtat_pkg::ST_FULL;
            end else begin
                tracks[fill] = '{r.center_x, r.center_y, r.rect_width, r.rect_height,
                                 r.rect_angle};
                res.status      = rtat_pkg::ST_APPENDED;
                res.entry_index = fill[rtat_pkg::ENTRY_IDX_W-1:0];
                fill++;
            end
            add_expected(res);
        endfunction

        function void check_result(rtat_pkg::t_res got);
            rtat_pkg::t_res want;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d idx %0d", got.status,
                             got.entry_index);
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status || got.match_count !== want.match_count
                    || got.entry_index !== want.entry_index
                    || got.out_center_x !== want.out_center_x
                    || got.out_center_y !== want.out_center_y
                    || got.out_width !== want.out_width || got.out_height !== want.out_height
                    || got.out_angle !== want.out_angle || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch exp: st %0d mc %0d idx %0d c %h,%h s %h,%h a %h l %b",
                             want.status, want.match_count, want.entry_index,
                             want.out_center_x, want.out_center_y, want.out_width,
                             want.out_height, want.out_angle, want.last);
                    $display("         got: st %0d mc %0d idx %0d c %h,%h s %h,%h a %h l %b",
                             got.status, got.match_count, got.entry_index,
                             got.out_center_x, got.out_center_y, got.out_width,
                             got.out_height, got.out_angle, got.last);
                end
            end
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    rtat_pkg::t_req                  in_req    = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    rtat_pkg::t_res                  out_res;
    logic                            cfg_we    = 1'b0;
    logic [rtat_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [rtat_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    track_scoreboard board = new();
    bit              idle_on = 1'b1;
    int unsigned     stall_left = 0;
    int unsigned     cycle_count = 0;

    always #5 clk = ~clk;

    rect_track_association_table_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_res   (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // result monitor and receiver stall bursts
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_res);
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic rtat_pkg::t_req make_req(logic func, int cx, int cy, int w, int h,
                                                int ang, int area);
        rtat_pkg::t_req r;
        r.func         = func;
        r.center_x     = cx[rtat_pkg::COORD_W-1:0];
        r.center_y     = cy[rtat_pkg::COORD_W-1:0];
        r.rect_width   = w[rtat_pkg::COORD_W-1:0];
        r.rect_height  = h[rtat_pkg::COORD_W-1:0];
        r.rect_angle   = ang[rtat_pkg::ANGLE_W-1:0];
        r.contour_area = area[rtat_pkg::AREA_IN_W-1:0];
        return r;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int random_angle();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM;
    endfunction

    function automatic int random_area();
        int lo;
        lo = int'(board.min_area);
        if (lo > 0 && $urandom_range(0, 19) == 0)
            return $urandom_range(0, lo - 1);
        return $urandom_range(lo, AREA_MAX);
    endfunction

    // detection close to a stored track, mostly inside the match window
    function automatic rtat_pkg::t_req follow_req();
        rtat_pkg::t_entry e;
        int               rad, span, x, y, w, h, lo, hi;
        e = board.tracks[$urandom_range(0, board.fill - 1)];
        rad = int'(board.radius) << FRAC_BITS;
        case ($urandom_range(0, 9))
            0, 1:    span = 0;
            2:       span = rad + rad / 8 + 2;
            default: span = rad * 7 / 10;
        endcase
        x = clamp_coord(int'(e.center_x) + int'($urandom_range(0, 2 * span)) - span);
        y = clamp_coord(int'(e.center_y) + int'($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 5) == 0) begin
            lo = 40;
            hi = 180;
        end else begin
            lo = 88;
            hi = 115;
        end
        w = clamp_coord(int'(e.width) * int'($urandom_range(lo, hi)) / 100);
        h = clamp_coord(int'(e.height) * int'($urandom_range(lo, hi)) / 100);
        if ($urandom_range(0, 7) == 0) begin
            w = e.width;
            h = e.height;
        end
        return make_req(rtat_pkg::FUNC_SUBMIT, x, y, w, h, random_angle(), random_area());
    endfunction

    function automatic rtat_pkg::t_req random_req();
        int             c;
        rtat_pkg::t_req r;
        logic [31:0]    rnd;
        c = $urandom_range(0, 99);
        r = make_req(rtat_pkg::FUNC_SUBMIT, $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), random_angle(), random_area());
        if (c < 8) begin
            r.func = rtat_pkg::FUNC_DUMP;
        end else if (c < 13) begin
            // noise: every field random, function too
            rnd            = $urandom;
            r.func         = rnd[0];
            rnd            = $urandom;
            r.rect_angle   = rnd[rtat_pkg::ANGLE_W-1:0];
            rnd            = $urandom;
            r.contour_area = rnd[rtat_pkg::AREA_IN_W-1:0];
        end else if (c >= 30 && board.fill != 0) begin
            r = follow_req();
        end
        return r;
    endfunction

    task automatic send(input rtat_pkg::t_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_request(r);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [rtat_pkg::RADIUS_W-1:0] radius,
                              input logic [rtat_pkg::AREA_IN_W-1:0] min_area);
        logic [rtat_pkg::CFG_DATA_W-1:0] data;
        logic [rtat_pkg::CFG_IDX_W-1:0]  idx;
        logic [31:0]                     rnd;
        rnd  = $urandom;
        data = rnd[rtat_pkg::CFG_DATA_W-1:0];
        data[rtat_pkg::RADIUS_W-1:0] = radius;
        cfg_we   <= 1'b1;
        cfg_idx  <= rtat_pkg::REG_MATCH_RADIUS;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(rtat_pkg::REG_MATCH_RADIUS, data);
        cfg_idx  <= rtat_pkg::REG_MIN_AREA;
        cfg_data <= min_area;
        @(posedge clk);
        board.write_reg(rtat_pkg::REG_MIN_AREA, min_area);
        // write to an unused index, must be ignored
        rnd  = $urandom;
        idx  = REG_SPARE + {1'b0, rnd[0]};
        rnd  = $urandom;
        data = rnd[rtat_pkg::CFG_DATA_W-1:0];
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n);
        repeat (n) send(random_req());
    endtask

    initial begin
        logic [31:0] rnd_r, rnd_m;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, small areas, threshold edge, radius edge
        send(make_req(rtat_pkg::FUNC_DUMP, 0, 0, 0, 0, 0, 0));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 1600, 1600, 160, 160, -1440, 999));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 1600, 1600, 160, 160, 0, 0));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 1600, 1600, 160, 160, -1440, 1000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 1600, 1600, 160, 160, 1440, 1000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 1920, 1600, 160, 160, 5, AREA_MAX));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 1920, 1921, 160, 160, 7, AREA_MAX));
        // area ratio band edges and a double match
        send(make_req(rtat_pkg::FUNC_SUBMIT, 16000, 16000, 140, 1, 0, 5000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 16000, 16000, 100, 1, 0, 5000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 16000, 16000, 143, 1, 0, 5000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 16000, 16000, 120, 1, 0, 5000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 16000, 16000, 85, 1, 0, 5000));
        // zero areas
        send(make_req(rtat_pkg::FUNC_SUBMIT, 32000, 32000, 0, 5, 0, 5000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 32000, 32000, 7, 0, 0, 5000));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 32000, 32000, 1, 1, 0, 5000));
        // extreme fields, angles beyond the nominal range
        send(make_req(rtat_pkg::FUNC_SUBMIT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 2047,
                      AREA_MAX));
        send(make_req(rtat_pkg::FUNC_SUBMIT, 0, 0, COORD_MAX, COORD_MAX, -2048, AREA_MAX));
        send(make_req(rtat_pkg::FUNC_DUMP, 0, 0, 0, 0, 0, 0));
        send(make_req(rtat_pkg::FUNC_DUMP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, -1,
                      AREA_MAX));

        wait_idle();
        set_config(8'd30, 21'd500);
        run_random(120);
        wait_idle();
        set_config(8'd0, 21'd0);
        run_random(80);
        wait_idle();
        set_config(8'd255, '1);
        run_random(20);
        wait_idle();
        rnd_r = $urandom_range(1, 254);
        rnd_m = $urandom_range(0, 5000);
        set_config(rnd_r[rtat_pkg::RADIUS_W-1:0], rnd_m[rtat_pkg::AREA_IN_W-1:0]);
        run_random(140);
        wait_idle();
        set_config(rtat_pkg::MATCH_RADIUS_RST, rtat_pkg::MIN_AREA_RST);
        idle_on = 1'b0;
        run_random(120);
        wait_idle();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/rtat_pkg.sv
src/rect_track_association_table_core.sv
tb/sv/testbench.sv
